>>> rtl/core/fdsn_pkg.sv
`default_nettype none

package fdsn_pkg;

  // Counter width default, result field width and byte width
  localparam int COUNT_WIDTH_DEFAULT = 32;
  localparam int FIELD_WIDTH         = 32;
  localparam int BYTE_WIDTH          = 8;

  // Configuration port geometry
  localparam int PADDR_WIDTH = 3;
  localparam int PDATA_WIDTH = 32;
  localparam logic REG_SEPARATOR = 1'b0;

  // Counter slots
  localparam int CNT_NUM  = 6;
  localparam int CNT_A    = 0;
  localparam int CNT_C    = 1;
  localparam int CNT_G    = 2;
  localparam int CNT_T    = 3;
  localparam int CNT_READ = 4;
  localparam int CNT_EMIT = 5;

  // Characters of interest
  localparam logic [BYTE_WIDTH-1:0] CH_GT      = 8'h3E;
  localparam logic [BYTE_WIDTH-1:0] CH_NL      = 8'h0A;
  localparam logic [BYTE_WIDTH-1:0] CH_A       = 8'h61;
  localparam logic [BYTE_WIDTH-1:0] CH_C       = 8'h63;
  localparam logic [BYTE_WIDTH-1:0] CH_G       = 8'h67;
  localparam logic [BYTE_WIDTH-1:0] CH_T       = 8'h74;
  localparam logic [BYTE_WIDTH-1:0] CH_UPPER_A = 8'h41;
  localparam logic [BYTE_WIDTH-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [BYTE_WIDTH-1:0] CASE_BIT   = 8'h20;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_HEADER = 2'd1,
    PH_SEQ    = 2'd2,
    PH_ERROR  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_OK    = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    logic clr;
    logic inc;
  } cnt_ctrl_t;

  // Fold upper-case letters only
  function automatic logic [BYTE_WIDTH-1:0] to_lower(input logic [BYTE_WIDTH-1:0] b);
    if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
      return b | CASE_BIT;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/fdsn_sat_counter.sv
`default_nettype none

module fdsn_sat_counter #(
  parameter int COUNT_WIDTH = fdsn_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire fdsn_pkg::cnt_ctrl_t              ctrl,
  output logic [fdsn_pkg::FIELD_WIDTH-1:0]      field
);
  import fdsn_pkg::*;

  logic [COUNT_WIDTH-1:0] count;

  // Clear on summary, otherwise count up and stick at all ones
  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      count <= '0;
    end else if (ctrl.inc && (count != {COUNT_WIDTH{1'b1}})) begin
      count <= count + 1'b1;
    end
  end

  // Fit the count into the result field, saturating when wider
  generate
    if (COUNT_WIDTH > FIELD_WIDTH) begin : g_wide
      assign field = (|count[COUNT_WIDTH-1:FIELD_WIDTH]) ? {FIELD_WIDTH{1'b1}}
                                                          : count[FIELD_WIDTH-1:0];
    end else if (COUNT_WIDTH == FIELD_WIDTH) begin : g_equal
      assign field = count;
    end else begin : g_narrow
      assign field = {{(FIELD_WIDTH-COUNT_WIDTH){1'b0}}, count};
    end
  endgenerate

endmodule

`default_nettype wire

>>> rtl/core/fasta_dna_stream_normalizer_core.sv
// Multi-FASTA stream normalizer.
// Input channel (in_valid/in_ready) carries one text byte per item in byte_in,
// or an end marker when end_of_file is high (byte_in is then ignored).
// Output channel (out_valid/out_ready) carries at most one result per item:
// kind 0 is a normalized sequence byte in byte_out (lower-case base or the
// separator), kind 1 or 2 is the end summary with the six counts.
// Headers and newlines yield nothing. The first byte must be '>'.
// An item is held in an input register, then its result is loaded into the
// output register once that register is empty or being read. One item per cycle
// is sustained while out_ready stays high; the input register and the output
// register each hold one item. When out_ready is low and a result waits, the
// input register holds its item and in_ready drops once it is full; nothing is
// lost.
// Reset (rst, synchronous) clears parser state, all counts, the valid flags of
// both pipeline registers and the separator register. The end item also clears
// parser state and counts, but not the separator.
// The APB port holds the separator register at address 0; pready is always 1.
`default_nettype none

module fasta_dna_stream_normalizer_core #(
  parameter int COUNT_WIDTH = fdsn_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [fdsn_pkg::PADDR_WIDTH-1:0]   paddr,
  input  wire logic [fdsn_pkg::PDATA_WIDTH-1:0]   pwdata,
  output logic      [fdsn_pkg::PDATA_WIDTH-1:0]   prdata,
  output logic                                    pready,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [fdsn_pkg::BYTE_WIDTH-1:0]    byte_in,
  input  wire logic                               end_of_file,
  // output channel
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [1:0]                              kind,
  output logic [fdsn_pkg::BYTE_WIDTH-1:0]         byte_out,
  output logic [fdsn_pkg::FIELD_WIDTH-1:0]        count_a,
  output logic [fdsn_pkg::FIELD_WIDTH-1:0]        count_c,
  output logic [fdsn_pkg::FIELD_WIDTH-1:0]        count_g,
  output logic [fdsn_pkg::FIELD_WIDTH-1:0]        count_t,
  output logic [fdsn_pkg::FIELD_WIDTH-1:0]        sequence_chars,
  output logic [fdsn_pkg::FIELD_WIDTH-1:0]        bytes_emitted
);
  import fdsn_pkg::*;

  // Configuration register
  logic [BYTE_WIDTH-1:0] separator;

  // Input register
  logic                  s1_valid;
  logic [BYTE_WIDTH-1:0] s1_byte;
  logic                  s1_eof;
  logic                  advance;

  // Parser state
  phase_t phase, phase_next;
  logic   nonempty, nonempty_next;

  // Processing results
  logic                  emit;
  kind_t                 emit_kind;
  logic [BYTE_WIDTH-1:0] emit_byte;
  logic [BYTE_WIDTH-1:0] lower;
  logic [CNT_NUM-1:0]    inc;

  // Counters
  cnt_ctrl_t             cnt_ctrl  [CNT_NUM];
  logic [FIELD_WIDTH-1:0] cnt_field [CNT_NUM];

  // Output register
  kind_t                  out_kind;
  logic [BYTE_WIDTH-1:0]  out_byte;
  logic [FIELD_WIDTH-1:0] out_cnt [CNT_NUM];

  // APB access: only the separator register is decoded
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SEPARATOR)
                  ? {{(PDATA_WIDTH-BYTE_WIDTH){1'b0}}, separator} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      separator <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SEPARATOR)) begin
      separator <= pwdata[BYTE_WIDTH-1:0];
    end
  end

  // Advance the input register whenever the output register can take a result
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= byte_in;
      s1_eof  <= end_of_file;
    end
  end

  // Parse one item
  assign lower = to_lower(s1_byte);

  always_comb begin
    phase_next    = phase;
    nonempty_next = nonempty;
    emit          = 1'b0;
    emit_kind     = KIND_BYTE;
    emit_byte     = '0;
    inc           = '0;
    if (s1_eof) begin
      emit          = 1'b1;
      emit_kind     = ((phase == PH_START) || (phase == PH_ERROR)) ? KIND_ERROR : KIND_OK;
      phase_next    = PH_START;
      nonempty_next = 1'b0;
    end else begin
      unique case (phase)
        PH_START: begin
          phase_next = (s1_byte == CH_GT) ? PH_HEADER : PH_ERROR;
        end
        PH_HEADER: begin
          if (s1_byte == CH_NL) begin
            phase_next    = PH_SEQ;
            nonempty_next = 1'b0;
          end
        end
        PH_SEQ: begin
          if (s1_byte == CH_GT) begin
            // close the record, with a separator if it held anything
            phase_next = PH_HEADER;
            if (nonempty) begin
              nonempty_next  = 1'b0;
              emit           = 1'b1;
              emit_byte      = separator;
              inc[CNT_EMIT]  = 1'b1;
            end
          end else if (s1_byte != CH_NL) begin
            nonempty_next = 1'b1;
            emit          = 1'b1;
            inc[CNT_READ] = 1'b1;
            inc[CNT_EMIT] = 1'b1;
            emit_byte     = lower;
            case (lower)
              CH_A:    inc[CNT_A] = 1'b1;
              CH_C:    inc[CNT_C] = 1'b1;
              CH_G:    inc[CNT_G] = 1'b1;
              CH_T:    inc[CNT_T] = 1'b1;
              default: emit_byte  = separator;
            endcase
          end
        end
        PH_ERROR: begin
          phase_next = PH_ERROR;
        end
        default: begin
          phase_next = PH_ERROR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_START;
      nonempty <= 1'b0;
    end else if (advance) begin
      phase    <= phase_next;
      nonempty <= nonempty_next;
    end
  end

  // Saturating totals
  generate
    for (genvar i = 0; i < CNT_NUM; i++) begin : g_cnt
      assign cnt_ctrl[i].clr = advance && s1_eof;
      assign cnt_ctrl[i].inc = advance && inc[i];
      fdsn_sat_counter #(
        .COUNT_WIDTH (COUNT_WIDTH)
      ) u_cnt (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (cnt_ctrl[i]),
        .field (cnt_field[i])
      );
    end
  endgenerate

  // Output register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind <= emit_kind;
      out_byte <= emit_byte;
      for (int i = 0; i < CNT_NUM; i++) begin
        out_cnt[i] <= s1_eof ? cnt_field[i] : '0;
      end
    end
  end

  assign kind           = out_kind;
  assign byte_out       = out_byte;
  assign count_a        = out_cnt[CNT_A];
  assign count_c        = out_cnt[CNT_C];
  assign count_g        = out_cnt[CNT_G];
  assign count_t        = out_cnt[CNT_T];
  assign sequence_chars = out_cnt[CNT_READ];
  assign bytes_emitted  = out_cnt[CNT_EMIT];

endmodule

`default_nettype wire
